// ===== design/acts_pkg.sv =====
`timescale 1ns / 1ps
package acts_pkg;

    // Packed stream widths: fields packed from the lowest bit up, padded to bytes.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

    // Pairs reported per sweep before later pairs are dropped.
    localparam int MAX_RESULTS = 28;
    localparam int CNT_W       = 5;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_MARK  = 2'd1,
        KIND_SWEEP = 2'd2
    } kind_t;

    // One table entry as it sits in the box memory.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [2:0]         ctype;
        logic               listener;
    } box_t;

    // One result item.
    typedef struct packed {
        logic       status;
        logic [2:0] first_slot;
        logic [2:0] second_slot;
        logic       pair_valid;
        logic       notify_first;
        logic       notify_second;
        logic       last;
    } result_t;

    // Verdict of the pair tester.
    typedef struct packed {
        logic overlap;
        logic notify_first;
        logic notify_second;
    } pair_check_t;

endpackage

// ===== design/acts_pair_check.sv =====
`timescale 1ns / 1ps
module acts_pair_check
    import acts_pkg::*;
(
    input  box_t        box_a,
    input  box_t        box_b,
    input  logic [63:0] matrix,
    output pair_check_t check
);

    logic signed [16:0] a_x;
    logic signed [16:0] a_y;
    logic signed [16:0] b_x;
    logic signed [16:0] b_y;
    logic signed [16:0] a_r;
    logic signed [16:0] a_b;
    logic signed [16:0] b_r;
    logic signed [16:0] b_b;

    always_comb
    begin
        a_x = 17'(box_a.x);
        a_y = 17'(box_a.y);
        b_x = 17'(box_b.x);
        b_y = 17'(box_b.y);
        a_r = a_x + signed'({2'b00, box_a.w});
        a_b = a_y + signed'({2'b00, box_a.h});
        b_r = b_x + signed'({2'b00, box_b.w});
        b_b = b_y + signed'({2'b00, box_b.h});

        // Strict overlap: shared edges do not count.
        check.overlap = (a_x < b_r) && (a_r > b_x) && (a_y < b_b) && (a_b > b_y);

        // Bit a*8+b of the matrix says type a hears about type b.
        check.notify_first  = matrix[{box_a.ctype, box_b.ctype}] & box_a.listener;
        check.notify_second = matrix[{box_b.ctype, box_a.ctype}] & box_b.listener;
    end

endmodule

// ===== design/aabb_collider_table_sweep_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         tdata: rect fields and slot; tuser: kind
// m_axis    out        tdata: status, slots, notices; tuser: pair_valid; tlast: last
// cfg       in         cfg_wr_en / cfg_wr_data: interaction matrix
//
// Add, mark and unused kinds are handled on acceptance; the result is in the output
// register on the next cycle. A sweep purges marked slots; each live slot i below
// the top slot is checked against every higher slot, as the single read port of the
// box memory delivers one partner box per cycle while not stalled; dead slots are
// skipped. Output back-pressure stalls the scan in place on a hit with a pair held.
// Reset clears the slot flags, the matrix and all control state; the box memory
// keeps whatever it holds, since a slot only goes live once an add has written it.
module aabb_collider_table_sweep_unit
    import acts_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [63:0]           cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // rect_x[15:0], rect_y[31:16], rect_w[46:32], rect_h[61:47],
    // rect_type[64:62], has_listener[65], slot[68:66], zeros above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[0], first_slot[3:1], second_slot[6:4], notify_first[7],
    // notify_second[8], zeros above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // pair_valid[0]
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int KW = $clog2(SLOT_COUNT + 1);

    // The sweep walks the outer slot i, loads its box once, then streams every
    // higher slot k through the memory read port against it.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PURGE  = 7'b0000010,
        ST_NEXT_I = 7'b0000100,
        ST_GRAB   = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

    state_t                state_reg,      state_next;
    logic [63:0]           matrix_reg;
    logic [SLOT_COUNT-1:0] live_reg,       live_next;
    logic [SLOT_COUNT-1:0] marked_reg,     marked_next;
    logic [SW-1:0]         i_reg,          i_next;
    logic [KW-1:0]         k_reg,          k_next;
    logic                  c_valid_reg,    c_valid_next;
    logic [SW-1:0]         c_k_reg,        c_k_next;
    logic [CNT_W-1:0]      cnt_reg,        cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    result_t               pend_reg,       pend_next;
    logic                  out_valid_reg,  out_valid_next;
    result_t               out_reg,        out_next;
    box_t                  bi_reg,         bi_next;

    // Box memory with a registered read.
    box_t                  box_mem [SLOT_COUNT];
    box_t                  rd_data_reg;
    logic                  mem_we;
    logic [SW-1:0]         mem_wr_addr;
    box_t                  mem_wr_data;
    logic                  mem_re;
    logic [SW-1:0]         mem_rd_addr;

    box_t                  in_box;
    kind_t                 in_kind;
    logic [2:0]            in_slot;
    logic                  in_fire;
    logic                  out_can_load;
    logic                  free_found;
    logic [SW-1:0]         free_idx;
    pair_check_t           chk;
    logic                  hit;
    logic                  stall;
    result_t               new_pair;
    result_t               done_res;

    acts_pair_check u_pair_check (
        .box_a  (bi_reg),
        .box_b  (rd_data_reg),
        .matrix (matrix_reg),
        .check  (chk)
    );

    always_comb
    begin
        in_box.x        = s_axis_tdata[15:0];
        in_box.y        = s_axis_tdata[31:16];
        in_box.w        = s_axis_tdata[46:32];
        in_box.h        = s_axis_tdata[61:47];
        in_box.ctype    = s_axis_tdata[64:62];
        in_box.listener = s_axis_tdata[65];
        in_slot         = s_axis_tdata[68:66];
        in_kind         = kind_t'(s_axis_tuser);
    end

    assign out_can_load  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_can_load;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = SLOT_COUNT - 1; j >= 0; j--)
        begin
            if (!live_reg[j])
            begin
                free_found = 1'b1;
                free_idx   = SW'(j);
            end
        end
    end

    always_comb
    begin
        hit   = c_valid_reg && chk.overlap && (cnt_reg < CNT_W'(MAX_RESULTS));
        // A second hit can only be taken once the held one has somewhere to go.
        stall = hit && pend_valid_reg && !out_can_load;

        new_pair               = '0;
        new_pair.first_slot    = 3'(i_reg);
        new_pair.second_slot   = 3'(c_k_reg);
        new_pair.pair_valid    = 1'b1;
        new_pair.notify_first  = chk.notify_first;
        new_pair.notify_second = chk.notify_second;

        done_res      = '0;
        done_res.last = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        live_next       = live_reg;
        marked_next     = marked_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        c_valid_next    = c_valid_reg;
        c_k_next        = c_k_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        bi_next         = bi_reg;
        mem_we          = 1'b0;
        mem_wr_addr     = free_idx;
        mem_wr_data     = in_box;
        mem_re          = 1'b0;
        mem_rd_addr     = i_reg;

        out_valid_next  = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_kind)
                        KIND_ADD:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = done_res;
                            if (free_found)
                            begin
                                mem_we                = 1'b1;
                                live_next[free_idx]   = 1'b1;
                                marked_next[free_idx] = 1'b0;
                                out_next.first_slot   = 3'(free_idx);
                            end
                            else
                            begin
                                out_next.status = 1'b1;
                            end
                        end
                        KIND_MARK:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = done_res;
                            for (int j = 0; j < SLOT_COUNT; j++)
                            begin
                                if ((int'(in_slot) == j) && live_reg[j])
                                begin
                                    marked_next[j] = 1'b1;
                                end
                            end
                        end
                        KIND_SWEEP:
                        begin
                            state_next = ST_PURGE;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = done_res;
                        end
                    endcase
                end
            end

            ST_PURGE:
            begin
                live_next       = live_reg & ~marked_reg;
                marked_next     = '0;
                i_next          = '0;
                cnt_next        = '0;
                pend_valid_next = 1'b0;
                state_next      = ST_NEXT_I;
            end

            ST_NEXT_I:
            begin
                priority if (i_reg == SW'(SLOT_COUNT - 1))
                begin
                    state_next = ST_FINISH;
                end
                else if (live_reg[i_reg])
                begin
                    mem_re      = 1'b1;
                    mem_rd_addr = i_reg;
                    state_next  = ST_GRAB;
                end
                else
                begin
                    i_next = i_reg + SW'(1);
                end
            end

            ST_GRAB:
            begin
                bi_next      = rd_data_reg;
                mem_re       = 1'b1;
                mem_rd_addr  = i_reg + SW'(1);
                c_valid_next = live_reg[i_reg + SW'(1)];
                c_k_next     = i_reg + SW'(1);
                k_next       = KW'(i_reg) + KW'(2);
                state_next   = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = new_pair;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                    if (k_reg < KW'(SLOT_COUNT))
                    begin
                        mem_re       = 1'b1;
                        mem_rd_addr  = k_reg[SW-1:0];
                        c_valid_next = live_reg[k_reg[SW-1:0]];
                        c_k_next     = k_reg[SW-1:0];
                        k_next       = k_reg + KW'(1);
                    end
                    else
                    begin
                        c_valid_next = 1'b0;
                        i_next       = i_reg + SW'(1);
                        state_next   = ST_NEXT_I;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_can_load)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next = done_res;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            matrix_reg     <= '0;
            live_reg       <= '0;
            marked_reg     <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            c_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                matrix_reg <= cfg_wr_data;
            end
            live_reg       <= live_next;
            marked_reg     <= marked_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            c_valid_reg    <= c_valid_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        c_k_reg  <= c_k_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
        bi_reg   <= bi_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            box_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= box_mem[mem_rd_addr];
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {7'b0000000, out_reg.notify_second, out_reg.notify_first,
                              out_reg.second_slot, out_reg.first_slot, out_reg.status};
    assign m_axis_tuser[0] = out_reg.pair_valid;
    assign m_axis_tlast    = out_reg.last;

endmodule

// ===== design/acts_checker.sv =====
`timescale 1ns / 1ps
module acts_checker #(
    parameter int SLOT_COUNT = 8
)(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A new item is only taken when the output register has room for its result.
    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("item accepted while a result is stuck");

    // A result that is not a pair carries no partner slot and no notices.
    a_no_pair_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[8:4] == 5'd0)
        else $error("non-pair result carries pair fields");

    // A full table is reported as a single, final, non-pair result.
    a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tlast && !m_axis_tuser[0])
        else $error("table-full result is not a lone final item");

    // Pairs come lower slot first.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            SLOT_COUNT > 8 || m_axis_tdata[3:1] < m_axis_tdata[6:4])
        else $error("pair slots out of order");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind aabb_collider_table_sweep_unit acts_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_acts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
